// File: design/ssrl_pkg.sv
// Package for the servo slew-rate limiter: widths, register indexes,
// reset values, configuration and datapath command structs.
// No dependencies.
package ssrl_pkg;

    localparam int DATA_W    = 16;
    localparam int STEP_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DIV_STEPS = PROD_W / 2;   // two quotient bits per cycle
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Opcodes of an input item
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW     = 3'd4;

    // Reset values
    localparam logic signed [DATA_W-1:0] RST_CMD_MIN  = -16'sd127;
    localparam logic signed [DATA_W-1:0] RST_CMD_MAX  = 16'sd127;
    localparam logic signed [DATA_W-1:0] RST_PHYS_MIN = -16'sd3840;
    localparam logic signed [DATA_W-1:0] RST_PHYS_MAX = 16'sd3840;
    localparam logic [STEP_W-1:0]        RST_SLEW     = 15'd960;

    typedef struct packed {
        logic signed [DATA_W-1:0] cmd_min;
        logic signed [DATA_W-1:0] cmd_max;
        logic signed [DATA_W-1:0] phys_min;
        logic signed [DATA_W-1:0] phys_max;
        logic [STEP_W-1:0]        slew_step;
    } t_cfg;

    typedef struct packed {
        logic cmd_write;   // clamp and store a command
        logic tick_start;  // latch differences for the target
        logic mult;        // form product magnitude, load divider
        logic div_step;    // two restoring division steps
        logic target;      // sign, offset and saturate the target
        logic slew;        // move position toward target
        logic out_load;    // capture result into output register
    } t_dp_cmd;

endpackage

// File: design/ssrl_if.sv
// Channel interfaces of the servo slew-rate limiter: input items,
// result items and configuration writes.
// Depends on ssrl_pkg.
interface ssrl_in_if import ssrl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [DATA_W-1:0] command_value;

    modport source (output valid, opcode, command_value, input ready);
    modport sink   (input valid, opcode, command_value, output ready);
endinterface

interface ssrl_out_if import ssrl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] held_command;

    modport source (output valid, position, held_command, input ready);
    modport sink   (input valid, position, held_command, output ready);
endinterface

interface ssrl_cfg_if import ssrl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ssrl_regs.sv
// Configuration register file of the servo slew-rate limiter.
// Depends on ssrl_pkg and ssrl_cfg_if.
module ssrl_regs import ssrl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssrl_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    // Writes are always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_min   <= RST_CMD_MIN;
            r_cfg.cmd_max   <= RST_CMD_MAX;
            r_cfg.phys_min  <= RST_PHYS_MIN;
            r_cfg.phys_max  <= RST_PHYS_MAX;
            r_cfg.slew_step <= RST_SLEW;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_CMD_MIN:  r_cfg.cmd_min   <= i_cfg.data;
                CFG_CMD_MAX:  r_cfg.cmd_max   <= i_cfg.data;
                CFG_PHYS_MIN: r_cfg.phys_min  <= i_cfg.data;
                CFG_PHYS_MAX: r_cfg.phys_max  <= i_cfg.data;
                CFG_SLEW:     r_cfg.slew_step <= i_cfg.data[STEP_W-1:0];
                default: ;    // unmapped index, write ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/ssrl_datapath.sv
// Datapath of the servo slew-rate limiter: command clamp, target mapping
// with a radix-4 restoring divider, slew step and output register.
// Depends on ssrl_pkg.
module ssrl_datapath import ssrl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  t_cfg                     i_cfg,
    input  logic signed [DATA_W-1:0] i_command_value,
    output logic signed [DATA_W-1:0] o_position,
    output logic signed [DATA_W-1:0] o_held_command
);

    // Architectural state
    logic signed [DATA_W-1:0] r_cmd, n_cmd;
    logic signed [DATA_W-1:0] r_pos, n_pos;

    // Working registers of one tick
    logic signed [DIFF_W-1:0] r_a, r_b, r_span;
    logic [PROD_W-1:0]        r_quo, n_quo;
    logic [DATA_W-1:0]        r_den;
    logic [DATA_W-1:0]        r_rem, n_rem;
    logic                     r_neg;
    logic                     r_span_zero;
    logic signed [DATA_W-1:0] r_target, n_target;

    logic signed [DATA_W-1:0] r_out_pos, r_out_cmd;

    logic [DIFF_W-1:0] a_abs, b_abs, s_abs;
    logic [DIFF_W:0]   rem_t;
    logic [PROD_W-1:0] quo_t;

    logic signed [PROD_W+1:0] t_wide;
    logic signed [DATA_W+1:0] p_ext, tg_ext, s_ext;

    // Write clamp: upper limit tested first
    always_comb begin
        if (i_command_value > i_cfg.cmd_max) begin
            n_cmd = i_cfg.cmd_max;
        end else if (i_command_value < i_cfg.cmd_min) begin
            n_cmd = i_cfg.cmd_min;
        end else begin
            n_cmd = i_command_value;
        end
    end

    // Magnitudes of the latched differences, all below 2^16
    assign a_abs = r_a[DIFF_W-1]    ? -r_a    : r_a;
    assign b_abs = r_b[DIFF_W-1]    ? -r_b    : r_b;
    assign s_abs = r_span[DIFF_W-1] ? -r_span : r_span;

    // Two restoring division steps per cycle
    always_comb begin
        rem_t = '0;
        quo_t = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            rem_t = {1'b0, n_rem, quo_t[PROD_W-1]};
            quo_t = {quo_t[PROD_W-2:0], 1'b0};
            if (rem_t >= {2'b00, r_den}) begin
                rem_t    = rem_t - {2'b00, r_den};
                quo_t[0] = 1'b1;
            end
            n_rem = rem_t[DATA_W-1:0];
        end
        n_quo = quo_t;
    end

    // Signed quotient plus offset, saturated to 16 bits; phys_min if the span is zero
    always_comb begin
        if (r_neg) begin
            t_wide = $signed({{(PROD_W+2-DATA_W){i_cfg.phys_min[DATA_W-1]}},
                              i_cfg.phys_min})
                     - $signed({2'b00, r_quo});
        end else begin
            t_wide = $signed({{(PROD_W+2-DATA_W){i_cfg.phys_min[DATA_W-1]}},
                              i_cfg.phys_min})
                     + $signed({2'b00, r_quo});
        end
        if (r_span_zero) begin
            n_target = i_cfg.phys_min;
        end else if (t_wide > $signed((PROD_W+2)'(32767))) begin
            n_target = 16'sh7FFF;
        end else if (t_wide < -$signed((PROD_W+2)'(32768))) begin
            n_target = -16'sh8000;
        end else begin
            n_target = t_wide[DATA_W-1:0];
        end
    end

    // Slew toward the target without overshoot
    always_comb begin
        p_ext  = {{2{r_pos[DATA_W-1]}}, r_pos};
        tg_ext = {{2{r_target[DATA_W-1]}}, r_target};
        s_ext  = '0;
        n_pos  = r_pos;
        if (p_ext < tg_ext) begin
            s_ext = p_ext + $signed({3'b000, i_cfg.slew_step});
            n_pos = (s_ext > tg_ext) ? r_target : s_ext[DATA_W-1:0];
        end else if (p_ext > tg_ext) begin
            s_ext = p_ext - $signed({3'b000, i_cfg.slew_step});
            n_pos = (s_ext < tg_ext) ? r_target : s_ext[DATA_W-1:0];
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
            r_pos <= '0;
        end else begin
            if (i_cmd.cmd_write) begin
                r_cmd <= n_cmd;
            end
            if (i_cmd.slew) begin
                r_pos <= n_pos;
            end
        end
    end

    // Working and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_a    <= DIFF_W'(r_cmd) - DIFF_W'(i_cfg.cmd_min);
            r_b    <= DIFF_W'(i_cfg.phys_max) - DIFF_W'(i_cfg.phys_min);
            r_span <= DIFF_W'(i_cfg.cmd_max) - DIFF_W'(i_cfg.cmd_min);
        end
        if (i_cmd.mult) begin
            r_quo       <= a_abs[DATA_W-1:0] * b_abs[DATA_W-1:0];
            r_den       <= s_abs[DATA_W-1:0];
            r_rem       <= '0;
            r_neg       <= r_a[DIFF_W-1] ^ r_b[DIFF_W-1] ^ r_span[DIFF_W-1];
            r_span_zero <= (r_span == '0);
        end
        if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (i_cmd.target) begin
            r_target <= n_target;
        end
        if (i_cmd.out_load) begin
            r_out_pos <= r_pos;
            r_out_cmd <= r_cmd;
        end
    end

    assign o_position     = r_out_pos;
    assign o_held_command = r_out_cmd;

endmodule

// File: design/ssrl_ctrl.sv
// Controller of the servo slew-rate limiter: sequences the datapath
// through one item and owns the input and output handshakes.
// Depends on ssrl_pkg.
module ssrl_ctrl import ssrl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_DIV,
        S_TGT,
        S_SLEW,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_out_valid;
    logic                   in_fire;
    logic                   cnt_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign cnt_last   = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OPC_WRITE) begin
                        o_cmd.cmd_write = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = S_MULT;
                    end
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (cnt_last) begin
                    n_state = S_TGT;
                end
            end
            S_TGT: begin
                o_cmd.target = 1'b1;
                n_state      = S_SLEW;
            end
            S_SLEW: begin
                o_cmd.slew = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // Wait until the output register is free or draining
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, divider step count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MULT) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while pending");

    // A write item goes straight to the result stage
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_opcode == OPC_WRITE) |=> (r_state == S_DONE))
        else $error("write item did not reach result stage");

    // A tick runs the full divider before the target is formed
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TGT) |-> ($past(r_state) == S_DIV && $past(cnt_last)))
        else $error("target formed before divider finished");

    // Loading a result always pairs with a valid result next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

// File: design/servo_slew_rate_limiter_core.sv
// Servo slew-rate limiter, top level: a command write clamps and stores
// the command; a tick maps it onto the physical range and slews the
// position. Each item gives one result. Depends on ssrl_pkg, ssrl_if,
// ssrl_regs, ssrl_ctrl and ssrl_datapath.
//
// A command write clamps and stores the command in its transfer cycle,
// then loads the result once the output register is free or draining.
// A tick latches the differences, forms the 16x16 product, runs the
// radix-4 restoring divider that forms the mapped target, saturates
// the target, takes the slew step and loads the result.
// One item is worked on at a time; the next is taken as soon as the result
// sits in the output register, even while that result waits to be taken.
// Configuration writes are always accepted and must be made while idle.
module servo_slew_rate_limiter_core import ssrl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssrl_in_if.sink   i_cmd,
    ssrl_out_if.source o_res,
    ssrl_cfg_if.sink  i_cfg
);

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    logic    in_ready;
    logic    out_valid;

    // Configuration registers
    ssrl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Sequencer
    ssrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_opcode    (i_cmd.opcode),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (dp_cmd)
    );

    // Arithmetic and result register
    ssrl_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_cfg           (cfg),
        .i_command_value (i_cmd.command_value),
        .o_position      (o_res.position),
        .o_held_command  (o_res.held_command)
    );

    assign i_cmd.ready = in_ready;
    assign o_res.valid = out_valid;

endmodule
